@@ rtl/see_pkg.sv @@
// see_pkg: shared types, constants and byte-forming functions of the
// string escape encoder. No dependencies.
`timescale 1ns / 1ps

package see_pkg;

  localparam int CP_W           = 21;
  localparam int BYTE_W         = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int LEN_W          = 4;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [CP_W-1:0] QUOTE_RESET = 21'd34;

  // Characters used in escape sequences
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LO_U   = 8'h75;
  localparam logic [7:0] CH_UP_U   = 8'h55;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ASCII_ONLY   = 3'd0,
    REG_NO_STDC      = 3'd1,
    REG_PCRE_MODE    = 3'd2,
    REG_ESCAPE_PUNCT = 3'd3,
    REG_QUOTE_ENABLE = 3'd4,
    REG_QUOTE_CHAR   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic            ascii_only;
    logic            no_stdc;
    logic            pcre_mode;
    logic            escape_punct;
    logic            quote_enable;
    logic [CP_W-1:0] quote_char;
  } cfg_t;

  // Output form chosen by the front end
  typedef enum logic [2:0] {
    K_STDC  = 3'd0,  // \0 \a ... \r
    K_HEX2  = 3'd1,  // \xHH
    K_BSUTF = 3'd2,  // backslash then UTF-8
    K_UTF   = 3'd3,  // plain UTF-8
    K_PCRE  = 3'd4,  // \x{h..}
    K_U4    = 3'd5,  // \uHHHH
    K_U8    = 3'd6   // \UHHHHHHHH
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [CP_W-1:0]  cp;
    logic [2:0]       ulen;  // UTF-8 length, 1..4
    logic [2:0]       ndig;  // hex digits in pcre form, 1..6
    logic [LEN_W-1:0] len;   // total bytes, 1..10
  } desc_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    hex_char = (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h57 + {4'h0, nib});
  endfunction

  function automatic logic [7:0] stdc_letter(input logic [3:0] c);
    logic [7:0] r;
    unique case (c)
      4'd0:    r = 8'h30;  // 0
      4'd7:    r = 8'h61;  // a
      4'd8:    r = 8'h62;  // b
      4'd9:    r = 8'h74;  // t
      4'd10:   r = 8'h6e;  // n
      4'd11:   r = 8'h76;  // v
      4'd12:   r = 8'h66;  // f
      default: r = 8'h72;  // r
    endcase
    return r;
  endfunction

  function automatic logic is_punct(input logic [CP_W-1:0] c);
    is_punct = (c >= 21'h21 && c <= 21'h2f) || (c >= 21'h3a && c <= 21'h40) ||
               (c >= 21'h5b && c <= 21'h60) || (c >= 21'h7b && c <= 21'h7e);
  endfunction

  function automatic logic [2:0] utf8_len(input logic [CP_W-1:0] c);
    logic [2:0] r;
    priority if (c < 21'h80)    r = 3'd1;
    else if (c < 21'h800)       r = 3'd2;
    else if (c < 21'h10000)     r = 3'd3;
    else                        r = 3'd4;
    return r;
  endfunction

  function automatic logic [2:0] pcre_digits(input logic [CP_W-1:0] c);
    logic [2:0] r;
    priority if (c[20])         r = 3'd6;
    else if (c[19:16] != 4'h0)  r = 3'd5;
    else if (c[15:12] != 4'h0)  r = 3'd4;
    else if (c[11:8] != 4'h0)   r = 3'd3;
    else if (c[7:4] != 4'h0)    r = 3'd2;
    else                        r = 3'd1;
    return r;
  endfunction

  // Byte j of the UTF-8 encoding of c, ulen bytes long
  function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] c,
                                           input logic [2:0] ulen,
                                           input logic [LEN_W-1:0] j);
    logic [7:0] r;
    logic [2:0] k;
    k = ulen - 3'd1 - j[2:0];
    if (ulen == 3'd1) begin
      r = c[7:0];
    end else if (j == '0) begin
      unique case (ulen)
        3'd2:    r = {3'b110, c[10:6]};
        3'd3:    r = {4'b1110, c[15:12]};
        default: r = {5'b11110, c[20:18]};
      endcase
    end else begin
      unique case (k)
        3'd0:    r = {2'b10, c[5:0]};
        3'd1:    r = {2'b10, c[11:6]};
        default: r = {2'b10, c[17:12]};
      endcase
    end
    return r;
  endfunction

  // Nibble n of c, zero above bit 20
  function automatic logic [3:0] nib_of(input logic [CP_W-1:0] c,
                                        input logic [2:0] n);
    logic [3:0] r;
    unique case (n)
      3'd0:    r = c[3:0];
      3'd1:    r = c[7:4];
      3'd2:    r = c[11:8];
      3'd3:    r = c[15:12];
      3'd4:    r = c[19:16];
      3'd5:    r = {3'b000, c[20]};
      default: r = 4'h0;
    endcase
    return r;
  endfunction

  // Byte idx of the escaped sequence described by d
  function automatic logic [7:0] esc_byte(input desc_t d, input logic [LEN_W-1:0] idx);
    logic [7:0]       r;
    logic [LEN_W-1:0] nib;
    nib = '0;
    r   = CH_BSLASH;
    unique case (d.kind)
      K_STDC: begin
        if (idx != '0) r = stdc_letter(d.cp[3:0]);
      end
      K_HEX2: begin
        nib = 4'd3 - idx;
        if (idx == 4'd1) r = CH_X;
        else if (idx >= 4'd2) r = hex_char(nib_of(d.cp, nib[2:0]));
      end
      K_BSUTF: begin
        if (idx != '0) r = utf8_byte(d.cp, d.ulen, idx - 4'd1);
      end
      K_UTF: begin
        r = utf8_byte(d.cp, d.ulen, idx);
      end
      K_PCRE: begin
        nib = {1'b0, d.ndig} + 4'd2 - idx;
        if (idx == 4'd1) r = CH_X;
        else if (idx == 4'd2) r = CH_LBRACE;
        else if (idx == d.len - 4'd1) r = CH_RBRACE;
        else if (idx >= 4'd3) r = hex_char(nib_of(d.cp, nib[2:0]));
      end
      K_U4: begin
        nib = 4'd5 - idx;
        if (idx == 4'd1) r = CH_LO_U;
        else if (idx >= 4'd2) r = hex_char(nib_of(d.cp, nib[2:0]));
      end
      default: begin
        nib = 4'd9 - idx;
        if (idx == 4'd1) r = CH_UP_U;
        else if (idx >= 4'd2) r = hex_char(nib_of(d.cp, nib[2:0]));
      end
    endcase
    return r;
  endfunction

endpackage

@@ rtl/see_if.sv @@
// see_if: valid/ready channel interfaces for input code points, output
// bytes and configuration writes. Depends on see_pkg.
`timescale 1ns / 1ps

interface see_in_if;
  logic                      valid;
  logic                      ready;
  logic [see_pkg::CP_W-1:0]  code_point;
  modport source(output valid, output code_point, input ready);
  modport sink(input valid, input code_point, output ready);
endinterface

interface see_out_if;
  logic                        valid;
  logic                        ready;
  logic [see_pkg::BYTE_W-1:0]  out_byte;
  logic                        last_byte;
  modport source(output valid, output out_byte, output last_byte, input ready);
  modport sink(input valid, input out_byte, input last_byte, output ready);
endinterface

interface see_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [see_pkg::CFG_IDX_W-1:0]  index;
  logic [see_pkg::CP_W-1:0]       data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

@@ rtl/see_front.sv @@
// see_front: accepts code points and classifies each into an escape
// descriptor for the queue. Depends on see_pkg and see_if.
`timescale 1ns / 1ps

module see_front (
  see_in_if.sink          in_ch,
  input  see_pkg::cfg_t   cfg,
  input  logic            q_full,
  output logic            push,
  output see_pkg::desc_t  push_desc
);
  import see_pkg::*;

  logic [CP_W-1:0] c;
  logic            ctl_c;
  logic            ascii;
  logic [2:0]      ulen;
  logic [2:0]      ndig;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;
  assign c           = in_ch.code_point;

  // Rule order: C escape, control hex, backslash prefix, pass, hex forms
  always_comb begin
    ctl_c = (c == '0) || (c >= 21'd7 && c <= 21'd13);
    ascii = cfg.ascii_only || cfg.pcre_mode;
    ulen  = utf8_len(c);
    ndig  = pcre_digits(c);
    push_desc.cp   = c;
    push_desc.ulen = ulen;
    push_desc.ndig = ndig;
    priority if (!cfg.no_stdc && ctl_c) begin
      push_desc.kind = K_STDC;
      push_desc.len  = 4'd2;
    end else if (c <= 21'h1f || c == 21'h7f) begin
      push_desc.kind = K_HEX2;
      push_desc.len  = 4'd4;
    end else if (c == 21'h5c || (cfg.quote_enable && c == cfg.quote_char) ||
                 (cfg.escape_punct && c < 21'h80 && is_punct(c))) begin
      push_desc.kind = K_BSUTF;
      push_desc.len  = 4'd1 + {1'b0, ulen};
    end else if (c < 21'h80 || !ascii) begin
      push_desc.kind = K_UTF;
      push_desc.len  = {1'b0, ulen};
    end else if (cfg.pcre_mode) begin
      push_desc.kind = K_PCRE;
      push_desc.len  = 4'd4 + {1'b0, ndig};
    end else if (c <= 21'hffff) begin
      push_desc.kind = K_U4;
      push_desc.len  = 4'd6;
    end else begin
      push_desc.kind = K_U8;
      push_desc.len  = 4'd10;
    end
  end

endmodule

@@ rtl/see_queue.sv @@
// see_queue: small FIFO of escape descriptors between front and back end.
// Depends on see_pkg.
`timescale 1ns / 1ps

module see_queue #(
  parameter int DEPTH = see_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  see_pkg::desc_t  push_desc,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output see_pkg::desc_t  head
);
  import see_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t         entries_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = entries_r[rd_ptr_r];

  // Pointer and fill-count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_desc;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("queue count beyond depth");

endmodule

@@ rtl/see_back.sv @@
// see_back: byte sequencer that walks the head descriptor into the output
// register one byte per cycle while out_ch is not stalled. Uses see_pkg, see_if.
`timescale 1ns / 1ps

module see_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  see_pkg::desc_t  head,
  output logic            pop,
  see_out_if.source       out_ch
);
  import see_pkg::*;

  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic              last_r;
  logic              fire;
  logic              is_last;

  assign fire    = head_valid && (!out_valid_r || out_ch.ready);
  assign is_last = (idx_r == head.len - 4'd1);
  assign pop     = fire && is_last;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.last_byte = last_r;

  // Byte index and output slot control
  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (fire) begin
      idx_nxt       = is_last ? '0 : idx_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r <= esc_byte(head, idx_r);
      last_r     <= is_last;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> idx_r < head.len) else $error("byte index past sequence end");
  a_idx_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> idx_r == '0) else $error("byte index left over without item");
  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid_r && last_r) else $error("item retired without last byte");

endmodule

@@ rtl/string_escape_encoder.sv @@
// Escaping encoder: one code point in, 1 to 10 escaped UTF-8 bytes out.
// After acceptance a code point is written to the queue, then its first byte to
// the output register (empty queue, free output). Throughput: one-byte items pass
// at one per cycle while the output is ready; the back end emits one byte per cycle.
// Reset: synchronous, clears queue and output; registers return to defaults
// (all 0, quote_char 34). No clearing pass.
`timescale 1ns / 1ps

module string_escape_encoder #(
  parameter int QUEUE_DEPTH = see_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  see_in_if.sink     in_ch,
  see_out_if.source  out_ch,
  see_cfg_if.sink    cfg_ch
);
  import see_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  logic  q_full;
  logic  push;
  desc_t push_desc;
  logic  pop;
  logic  head_valid;
  desc_t head;

  assign cfg_ch.ready = 1'b1;

  // Register write decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_ASCII_ONLY:   cfg_nxt.ascii_only   = cfg_ch.data[0];
        REG_NO_STDC:      cfg_nxt.no_stdc      = cfg_ch.data[0];
        REG_PCRE_MODE:    cfg_nxt.pcre_mode    = cfg_ch.data[0];
        REG_ESCAPE_PUNCT: cfg_nxt.escape_punct = cfg_ch.data[0];
        REG_QUOTE_ENABLE: cfg_nxt.quote_enable = cfg_ch.data[0];
        REG_QUOTE_CHAR:   cfg_nxt.quote_char   = cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ascii_only   <= 1'b0;
      cfg_r.no_stdc      <= 1'b0;
      cfg_r.pcre_mode    <= 1'b0;
      cfg_r.escape_punct <= 1'b0;
      cfg_r.quote_enable <= 1'b0;
      cfg_r.quote_char   <= QUOTE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  see_front u_front (
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  see_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  see_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
